// ===== rtl/rcsfd_pkg.sv =====
package rcsfd_pkg;

    localparam logic [7:0]  HDR_FIRST          = 8'h20;
    localparam logic [7:0]  HDR_SECOND         = 8'h40;
    localparam logic [15:0] CSUM_INIT          = 16'hFFFF - 16'h0020 - 16'h0040;
    localparam logic [4:0]  POS_CSUM_LOW       = 5'd28;
    localparam logic [4:0]  POS_CSUM_HIGH      = 5'd29;
    localparam logic [11:0] CH_MIN_RESET       = 12'd1000;
    localparam logic [11:0] CH_MAX_RESET       = 12'd2000;
    localparam logic [11:0] CH_DEFAULT         = 12'd1500;

    // register indexes, selected by paddr[2]
    localparam logic REG_CH_MIN = 1'b0;
    localparam logic REG_CH_MAX = 1'b1;

    typedef logic [11:0] ch_value_t;

endpackage

// ===== rtl/rc_serial_frame_decoder.sv =====
// RC serial frame decoder.
// Input channel (in_valid/in_ready/rx_byte) takes one received byte per request
// and sustains one byte per cycle while in_ready is high. The block hunts for
// the header 0x20 0x40, collects 30 frame bytes, checks the 16-bit checksum
// and, on a match, clamps the first NUM_CHANNELS little-endian words to
// [channel_min, channel_max]. The clamped words go to the channel store and
// are sent on the output channel (out_valid/out_ready/channel_index/
// channel_value/last_channel), one request per cycle while the receiver does
// not stall, index 0 first, last_channel set on the final one. The edge that
// takes the last byte of a matching frame marks a run as pending, and each
// result is then unloaded from the channel store through a single output
// register.
// A stalled receiver holds the output register. Bytes keep being taken; only the
// last byte of a following frame waits (in_ready low) until the previous run has
// left the store. Reset: hunting for a header, no pending results, channel store
// at 1500, channel_min 1000, channel_max 2000. The user writes the registers
// over the APB port (channel_min at 0x0, channel_max at 0x4) only while the
// block is idle; the block itself does not enforce this.
module rc_serial_frame_decoder #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  channel_index,
    output logic [11:0] channel_value,
    output logic        last_channel
);

    localparam int BUF_DEPTH = 2 * NUM_CHANNELS;
    localparam int BUF_W     = $clog2(BUF_DEPTH);
    localparam int IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // configuration
    rcsfd_pkg::ch_value_t ch_min_reg;
    rcsfd_pkg::ch_value_t ch_max_reg;

    // framing
    logic        hdr_seen_reg;
    logic        in_frame_reg;
    logic [4:0]  pos_reg;
    logic [15:0] csum_reg;
    logic [15:0] csum_next;
    logic [7:0]  csum_low_reg;
    logic [7:0]  buf_reg [BUF_DEPTH];

    rcsfd_pkg::ch_value_t store_reg [NUM_CHANNELS];
    rcsfd_pkg::ch_value_t clamp_val [NUM_CHANNELS];

    // result run
    logic             busy_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [11:0]      out_value_reg;
    logic             out_last_reg;

    logic in_acc;
    logic frame_end;
    logic csum_ok;
    logic load;
    logic cfg_wr;

    function automatic rcsfd_pkg::ch_value_t clamp_word(
        input logic [15:0] w,
        input rcsfd_pkg::ch_value_t lo,
        input rcsfd_pkg::ch_value_t hi
    );
        rcsfd_pkg::ch_value_t r;
        if (w > {4'd0, hi})
        begin
            r = hi;
        end
        else if (w < {4'd0, lo})
        begin
            r = lo;
        end
        else
        begin
            r = w[11:0];
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            rcsfd_pkg::REG_CH_MIN: prdata = {20'd0, ch_min_reg};
            rcsfd_pkg::REG_CH_MAX: prdata = {20'd0, ch_max_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_min_reg <= rcsfd_pkg::CH_MIN_RESET;
            ch_max_reg <= rcsfd_pkg::CH_MAX_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == rcsfd_pkg::REG_CH_MIN)
            begin
                ch_min_reg <= pwdata[11:0];
            end
            else
            begin
                ch_max_reg <= pwdata[11:0];
            end
        end
    end

    // the checksum byte that closes a frame must wait while a run is unloading
    assign frame_end = in_frame_reg && (pos_reg == rcsfd_pkg::POS_CSUM_HIGH);
    assign in_ready  = !(frame_end && busy_reg);
    assign in_acc    = in_valid && in_ready;
    assign csum_next = csum_reg - {8'd0, rx_byte};
    assign csum_ok   = ({rx_byte, csum_low_reg} == csum_reg);
    assign load      = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            clamp_val[i] = clamp_word({buf_reg[2*i+1], buf_reg[2*i]}, ch_min_reg, ch_max_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_seen_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            pos_reg      <= 5'd0;
            csum_reg     <= rcsfd_pkg::CSUM_INIT;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                store_reg[i] <= rcsfd_pkg::CH_DEFAULT;
            end
        end
        else if (in_acc)
        begin
            if (!in_frame_reg)
            begin
                if (hdr_seen_reg && (rx_byte == rcsfd_pkg::HDR_SECOND))
                begin
                    hdr_seen_reg <= 1'b0;
                    in_frame_reg <= 1'b1;
                    pos_reg      <= 5'd0;
                    csum_reg     <= rcsfd_pkg::CSUM_INIT;
                end
                else
                begin
                    hdr_seen_reg <= (rx_byte == rcsfd_pkg::HDR_FIRST);
                end
            end
            else if (pos_reg < rcsfd_pkg::POS_CSUM_LOW)
            begin
                csum_reg <= csum_next;
                pos_reg  <= pos_reg + 5'd1;
            end
            else if (pos_reg == rcsfd_pkg::POS_CSUM_LOW)
            begin
                pos_reg <= pos_reg + 5'd1;
            end
            else
            begin
                if (csum_ok)
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        store_reg[i] <= clamp_val[i];
                    end
                end
                hdr_seen_reg <= 1'b0;
                in_frame_reg <= 1'b0;
                pos_reg      <= 5'd0;
                csum_reg     <= rcsfd_pkg::CSUM_INIT;
            end
        end
    end

    // frame byte capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc && in_frame_reg)
        begin
            if (pos_reg < 5'(BUF_DEPTH))
            begin
                buf_reg[pos_reg[BUF_W-1:0]] <= rx_byte;
            end
            if (pos_reg == rcsfd_pkg::POS_CSUM_LOW)
            begin
                csum_low_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc && frame_end && csum_ok)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (load)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_idx_reg   <= cnt_reg;
            out_value_reg <= store_reg[cnt_reg];
            out_last_reg  <= (cnt_reg == LAST_IDX);
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = 4'(out_idx_reg);
    assign channel_value = out_value_reg;
    assign last_channel  = out_last_reg;

    // a held result stays put while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_idx_reg)
            && $stable(out_value_reg) && $stable(out_last_reg)))
        else $error("result changed while receiver stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_idx_reg <= LAST_IDX))
        else $error("channel index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (pos_reg <= rcsfd_pkg::POS_CSUM_HIGH))
        else $error("byte position past end of frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !busy_reg) |-> 1'b0)
        else $error("result loaded without a pending run");

endmodule
